// ===== rtl/logodds_pkg.sv =====
// Package for the log-odds voxel occupancy grid.
// Holds the item types, the op and register codes, the controller command and status
// structs, and the sizing constants. It has no dependencies.
package logodds_pkg;

  localparam int unsigned MAX_SIZE = 32;
  localparam int unsigned LOG_W    = 16;
  localparam int unsigned IDX_W    = $clog2(MAX_SIZE);
  localparam int unsigned ADDR_W   = 3 * IDX_W;
  localparam int unsigned DEPTH    = MAX_SIZE * MAX_SIZE * MAX_SIZE;
  localparam int unsigned SIZE_W   = 6;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DECAY_W  = 15;

  localparam logic signed [LOG_W-1:0] HIT_INC_RST = 16'sd218;
  localparam logic signed [LOG_W-1:0] CLAMP_LO_RST = -16'sd512;
  localparam logic signed [LOG_W-1:0] CLAMP_HI_RST = 16'sd896;
  localparam logic signed [LOG_W-1:0] OCC_THR_RST = 16'sd0;
  localparam logic [DECAY_W-1:0]      DECAY_RST = '0;
  localparam logic [SIZE_W-1:0]       SIZE_RST = SIZE_W'(MAX_SIZE);

  typedef enum logic [1:0] {
    OP_HIT   = 2'd0,
    OP_DECAY = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIT_INC  = 3'd0,
    REG_CLAMP_LO = 3'd1,
    REG_CLAMP_HI = 3'd2,
    REG_OCC_THR  = 3'd3,
    REG_DECAY    = 3'd4,
    REG_SIZE_X   = 3'd5,
    REG_SIZE_Y   = 3'd6,
    REG_SIZE_Z   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    op_e               op;
    logic signed [7:0] voxel_x;
    logic signed [7:0] voxel_y;
    logic signed [7:0] voxel_z;
  } in_item_t;

  typedef struct packed {
    logic                    in_map;
    logic                    occupied;
    logic signed [LOG_W-1:0] cell_value;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // take the input item
    logic cnt_clr;   // restart the sweep counter
    logic cnt_inc;   // advance the sweep counter
    logic sweep_rd;  // decay sweep: read cell at counter
    logic wr_zero;   // clear sweep: write zero at counter
    logic rd_cell;   // read the addressed cell
    logic modify;    // hit update and result capture
    logic load_out;  // move result to the output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic decay_off;
    logic cnt_last;
  } ctl_sts_t;

endpackage

// ===== rtl/logodds_ctrl.sv =====
// Controller of the occupancy grid: sequences address calculation, cell
// read-modify-write, whole-grid sweeps and the output handshake.
// Depends on logodds_pkg.
module logodds_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logodds_pkg::ctl_sts_t sts_i,
  output logodds_pkg::ctl_cmd_t cmd_o
);
  import logodds_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CALC1,
    S_CALC2,
    S_DECAY,
    S_DRAIN,
    S_CLEAR,
    S_READ,
    S_MODIFY,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_INIT: begin
        cmd_o.wr_zero = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_CALC1;
      end
      S_CALC1: state_d = S_CALC2;
      S_CALC2: begin
        cmd_o.cnt_clr = 1'b1;
        if (sts_i.op == OP_CLEAR) begin
          state_d = S_CLEAR;
        end else if (sts_i.op == OP_DECAY && !sts_i.decay_off) begin
          state_d = S_DECAY;
        end else begin
          state_d = S_READ;
        end
      end
      S_DECAY: begin
        cmd_o.sweep_rd = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (sts_i.cnt_last) state_d = S_DRAIN;
      end
      // last decayed cell is written here
      S_DRAIN: state_d = S_READ;
      S_CLEAR: begin
        cmd_o.wr_zero = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) state_d = S_READ;
      end
      S_READ: begin
        cmd_o.rd_cell = 1'b1;
        state_d = S_MODIFY;
      end
      S_MODIFY: begin
        cmd_o.modify = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/logodds_dp.sv =====
// Datapath of the occupancy grid: configuration registers, voxel address
// pipeline, the cell memory with its update logic, sweep counter and result register.
// Depends on logodds_pkg.
module logodds_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [logodds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [logodds_pkg::CFG_W-1:0]  cfg_data_i,
  input  logodds_pkg::in_item_t          in_data_i,
  output logodds_pkg::out_item_t         out_data_o,
  input  logodds_pkg::ctl_cmd_t          cmd_i,
  output logodds_pkg::ctl_sts_t          sts_o
);
  import logodds_pkg::*;

  // configuration
  logic signed [LOG_W-1:0] hit_inc_q, clamp_lo_q, clamp_hi_q, occ_thr_q;
  logic [DECAY_W-1:0]      decay_q;
  logic [SIZE_W-1:0]       size_x_q, size_y_q, size_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_inc_q  <= HIT_INC_RST;
      clamp_lo_q <= CLAMP_LO_RST;
      clamp_hi_q <= CLAMP_HI_RST;
      occ_thr_q  <= OCC_THR_RST;
      decay_q    <= DECAY_RST;
      size_x_q   <= SIZE_RST;
      size_y_q   <= SIZE_RST;
      size_z_q   <= SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HIT_INC:  hit_inc_q  <= cfg_data_i;
        REG_CLAMP_LO: clamp_lo_q <= cfg_data_i;
        REG_CLAMP_HI: clamp_hi_q <= cfg_data_i;
        REG_OCC_THR:  occ_thr_q  <= cfg_data_i;
        REG_DECAY:    decay_q    <= cfg_data_i[DECAY_W-1:0];
        REG_SIZE_X:   size_x_q   <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Y:   size_y_q   <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Z:   size_z_q   <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes above the grid saturate
  logic [SIZE_W-1:0] sx_eff, sy_eff, sz_eff;
  assign sx_eff = (size_x_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_x_q;
  assign sy_eff = (size_y_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_y_q;
  assign sz_eff = (size_z_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_z_q;

  // captured item
  op_e               op_q;
  logic signed [7:0] vx_q, vy_q, vz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= in_data_i.op;
      vx_q <= in_data_i.voxel_x;
      vy_q <= in_data_i.voxel_y;
      vz_q <= in_data_i.voxel_z;
    end
  end

  // address stage A: range check and the two small products
  logic                  x_ok, y_ok, z_ok;
  logic                  inside_q;
  logic [2*SIZE_W-1:0]   syz_q;
  logic [IDX_W+SIZE_W-1:0] yz_q;
  logic [IDX_W-1:0]      x_q, z_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [IDX_W+2*SIZE_W-1:0] xsyz;

  assign x_ok = !vx_q[7] && ({1'b0, vx_q[6:0]} < {2'b00, sx_eff});
  assign y_ok = !vy_q[7] && ({1'b0, vy_q[6:0]} < {2'b00, sy_eff});
  assign z_ok = !vz_q[7] && ({1'b0, vz_q[6:0]} < {2'b00, sz_eff});

  always_ff @(posedge clk_i) begin
    inside_q <= x_ok && y_ok && z_ok;
    syz_q    <= sy_eff * sz_eff;
    yz_q     <= vy_q[IDX_W-1:0] * sz_eff;
    x_q      <= vx_q[IDX_W-1:0];
    z_q      <= vz_q[IDX_W-1:0];
  end

  // address stage B
  assign xsyz = x_q * syz_q;

  always_ff @(posedge clk_i) begin
    addr_q <= ADDR_W'(xsyz + (IDX_W+2*SIZE_W)'(yz_q) + (IDX_W+2*SIZE_W)'(z_q));
  end

  // sweep counter and pending decay write
  logic [ADDR_W-1:0] cnt_q, pend_addr_q;
  logic              pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      pend_q <= cmd_i.sweep_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= cnt_q;
  end

  // cell memory
  logic [LOG_W-1:0]        mem [DEPTH];
  logic signed [LOG_W-1:0] rdata_q;
  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       mem_wa, mem_ra;
  logic [LOG_W-1:0]        mem_wd;

  // hit: add, then clamp low, then clamp high
  logic signed [LOG_W:0]   hit_sum;
  logic signed [LOG_W:0]   hit_lo;
  logic signed [LOG_W-1:0] hit_val;

  always_comb begin
    hit_sum = {rdata_q[LOG_W-1], rdata_q} + {hit_inc_q[LOG_W-1], hit_inc_q};
    hit_lo  = (hit_sum < $signed({clamp_lo_q[LOG_W-1], clamp_lo_q})) ?
              {clamp_lo_q[LOG_W-1], clamp_lo_q} : hit_sum;
    hit_val = (hit_lo > $signed({clamp_hi_q[LOG_W-1], clamp_hi_q})) ?
              clamp_hi_q : hit_lo[LOG_W-1:0];
  end

  // decay toward zero without crossing it
  logic signed [LOG_W:0]   dec_ext, step_ext, dec_sum;
  logic signed [LOG_W-1:0] dec_val;

  always_comb begin
    dec_ext  = {rdata_q[LOG_W-1], rdata_q};
    step_ext = {{(LOG_W+1-DECAY_W){1'b0}}, decay_q};
    dec_val  = rdata_q;
    dec_sum  = dec_ext;
    if (rdata_q > 0) begin
      dec_sum = dec_ext - step_ext;
      dec_val = (dec_sum < 0) ? '0 : dec_sum[LOG_W-1:0];
    end else if (rdata_q < 0) begin
      dec_sum = dec_ext + step_ext;
      dec_val = (dec_sum > 0) ? '0 : dec_sum[LOG_W-1:0];
    end
  end

  always_comb begin
    mem_re = cmd_i.sweep_rd || cmd_i.rd_cell;
    mem_ra = cmd_i.sweep_rd ? cnt_q : addr_q;
    mem_we = pend_q || cmd_i.wr_zero || (cmd_i.modify && op_q == OP_HIT && inside_q);
    if (pend_q) begin
      mem_wa = pend_addr_q;
      mem_wd = dec_val;
    end else if (cmd_i.wr_zero) begin
      mem_wa = cnt_q;
      mem_wd = '0;
    end else begin
      mem_wa = addr_q;
      mem_wd = hit_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  // result and output registers
  logic signed [LOG_W-1:0] res_cell_q;
  out_item_t               out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.modify) begin
      if (!inside_q) begin
        res_cell_q <= '0;
      end else if (op_q == OP_HIT) begin
        res_cell_q <= hit_val;
      end else begin
        res_cell_q <= rdata_q;
      end
    end
    if (cmd_i.load_out) begin
      out_q.in_map     <= inside_q;
      out_q.occupied   <= inside_q && (res_cell_q > occ_thr_q);
      out_q.cell_value <= res_cell_q;
    end
  end

  assign out_data_o      = out_q;
  assign sts_o.op        = op_q;
  assign sts_o.decay_off = (decay_q == '0);
  assign sts_o.cnt_last  = &cnt_q;

endmodule

// ===== rtl/log_odds_voxel_occupancy_grid_top.sv =====
// Log-odds voxel occupancy grid, 32x32x32 cells of Q7.8 log-odds.
// Input item: op (hit, decay tick, query, clear) and a signed voxel index.
// Output item: in_map, occupied and the addressed cell value after the op.
// Both channels are valid/ready; one result item per input item, in order.
// Configuration: write enable, 3-bit register index, 16-bit data, taken
// at once; write only while the block is idle.
// Timing: one item at a time. A hit or query passes two address stages, the
// memory read, the update and the result load before its result is valid;
// no new item is taken until the block is back in idle after that result load.
// A decay tick with nonzero step walks all 32768 cells through the single
// memory read and write port, one cell a cycle. A clear writes zero to every
// cell.
// After reset a clearing pass writes every cell to zero; in_ready_o stays
// low throughout that pass. Config registers take their reset values at once.
// A stalled receiver holds the result in the output register; the next item is
// still taken and finishes internally, waiting for the output register to drain.
// Depends on logodds_pkg, logodds_ctrl and logodds_dp.
module log_odds_voxel_occupancy_grid_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [logodds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [logodds_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logodds_pkg::in_item_t             in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logodds_pkg::out_item_t            out_data_o
);
  import logodds_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  logodds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  logodds_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
